// ===== rtl/cfr_pkg.sv =====
package cfr_pkg;

    localparam int FRAME_LEN = 5;
    localparam int IDX_W     = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    localparam logic [7:0] START_BYTE = 8'hA5;
    localparam logic [7:0] END_BYTE   = 8'h5A;
    localparam logic [7:0] NAK_BYTE   = 8'h15;
    localparam logic [7:0] BUSY_BYTE  = 8'h16;
    localparam logic [7:0] STOP_ARG   = 8'hF5;

    localparam logic OP_RX_BYTE = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(FRAME_LEN - 1);

    typedef struct packed {
        logic       frame_ready;
        logic [7:0] command_code;
        logic [7:0] argument;
        logic       stop_request;
        logic       auto_active;
    } cfr_status_t;

    typedef struct packed {
        logic                       reply;
        logic [FRAME_LEN-1:0][7:0]  bytes;
        cfr_status_t                status;
    } cfr_job_t;

endpackage

// ===== rtl/cfr_front.sv =====
module cfr_front
    import cfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    input  logic        busy_req,
    input  logic        clear_buffer,
    input  logic        clear_stop,
    output cfr_job_t    job
);

    logic [FRAME_LEN-1:0][7:0] fb_reg, fb_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      recv_reg, recv_next;
    logic                      pend_reg, pend_next;
    logic                      auto_reg, auto_next;
    logic                      stop_reg, stop_next;

    always_comb
    begin
        logic [IDX_W-1:0] idx_base;
        logic [7:0]       sum;
        fb_next   = fb_reg;
        idx_next  = idx_reg;
        recv_next = recv_reg;
        pend_next = pend_reg;
        auto_next = auto_reg;
        stop_next = stop_reg;
        idx_base  = idx_reg;
        sum       = 8'd0;
        job.reply = 1'b0;
        job.bytes = fb_reg;
        if (opcode == OP_CONSUME)
        begin
            pend_next = 1'b0;
            recv_next = 1'b0;
            auto_next = 1'b0;
            if (clear_buffer)
            begin
                fb_next = '0;
            end
            if (clear_stop)
            begin
                stop_next = 1'b0;
            end
        end
        else if (rx_byte == START_BYTE && (!pend_reg || busy_req))
        begin
            recv_next = 1'b1;
            fb_next[0] = rx_byte;
            idx_next = IDX_W'(1);
        end
        else if (recv_reg)
        begin
            if (idx_reg < IDX_W'(FRAME_LEN))
            begin
                fb_next[idx_reg] = rx_byte;
                if (rx_byte == END_BYTE)
                begin
                    sum = fb_next[1] + fb_next[2];
                    job.reply = 1'b1;
                    if (sum == fb_next[3])
                    begin
                        if (!busy_req || fb_next[2] == STOP_ARG)
                        begin
                            job.bytes = fb_next;
                        end
                        else
                        begin
                            job.bytes = {FRAME_LEN{BUSY_BYTE}};
                        end
                        pend_next = 1'b1;
                        auto_next = 1'b1;
                    end
                    else
                    begin
                        job.bytes = {FRAME_LEN{NAK_BYTE}};
                        pend_next = 1'b0;
                    end
                    idx_base = '0;
                    if (fb_next[2] == STOP_ARG && auto_next)
                    begin
                        stop_next = 1'b1;
                    end
                end
            end
            else
            begin
                recv_next = 1'b0;
            end
            idx_next = idx_base + IDX_W'(1);
        end
        job.status.frame_ready  = pend_next;
        job.status.command_code = fb_next[1];
        job.status.argument     = fb_next[2];
        job.status.stop_request = stop_next;
        job.status.auto_active  = auto_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_reg   <= '0;
            idx_reg  <= '0;
            recv_reg <= 1'b0;
            pend_reg <= 1'b0;
            auto_reg <= 1'b0;
            stop_reg <= 1'b0;
        end
        else if (accept)
        begin
            fb_reg   <= fb_next;
            idx_reg  <= idx_next;
            recv_reg <= recv_next;
            pend_reg <= pend_next;
            auto_reg <= auto_next;
            stop_reg <= stop_next;
        end
    end

endmodule

// ===== rtl/cfr_queue.sv =====
module cfr_queue
    import cfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cfr_job_t  push_job,
    input  logic      pop,
    output cfr_job_t  head_job,
    output logic      empty,
    output logic      full
);

    cfr_job_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]     count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/cfr_back.sv =====
module cfr_back
    import cfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfr_job_t     head_job,
    input  logic         empty,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         tx_valid,
    output logic [7:0]   tx_byte,
    output logic         last,
    output cfr_status_t  status
);

    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             valid_reg, valid_next;
    logic             txv_reg, txv_next;
    logic [7:0]       txb_reg, txb_next;
    logic             last_reg, last_next;
    cfr_status_t      stat_reg, stat_next;
    logic             advance;
    logic             word_last;

    assign advance   = !valid_reg || !out_stall;
    assign word_last = !head_job.reply || (pos_reg == LAST_POS);
    assign pop       = advance && !empty && word_last;

    always_comb
    begin
        valid_next = valid_reg;
        pos_next   = pos_reg;
        txv_next   = txv_reg;
        txb_next   = txb_reg;
        last_next  = last_reg;
        stat_next  = stat_reg;
        if (advance)
        begin
            valid_next = !empty;
            txv_next   = head_job.reply;
            txb_next   = head_job.reply ? head_job.bytes[pos_reg] : 8'd0;
            last_next  = word_last;
            stat_next  = head_job.status;
            if (!empty)
            begin
                pos_next = word_last ? '0 : pos_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        txv_reg  <= txv_next;
        txb_reg  <= txb_next;
        last_reg <= last_next;
        stat_reg <= stat_next;
    end

    assign out_valid = valid_reg;
    assign tx_valid  = txv_reg;
    assign tx_byte   = txb_reg;
    assign last      = last_reg;
    assign status    = stat_reg;

endmodule

// ===== rtl/command_frame_receiver.sv =====
// channel  handshake             payload
// in       in_valid / in_stall   opcode, rx_byte, busy_req, clear_buffer, clear_stop
// out      out_valid / out_stall tx_valid, tx_byte, last and the five frame status fields
//
// one input word is classified and the frame state updated in the cycle it is
// accepted; a reply costs five output words, anything else one, so the output
// port and its out_stall set the rate
// the four-entry job queue takes new input words while replies drain
// reset is asynchronous, active low, and clears all frame state at once
// in_stall rises only when the job queue is full
module command_frame_receiver
    import cfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    input  logic        busy_req,
    input  logic        clear_buffer,
    input  logic        clear_stop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        last,
    output logic        frame_ready,
    output logic [7:0]  command_code,
    output logic [7:0]  argument,
    output logic        stop_request,
    output logic        auto_active
);

    cfr_job_t    front_job;
    cfr_job_t    head_job;
    cfr_status_t status;
    logic        q_empty;
    logic        q_full;
    logic        q_pop;
    logic        accept;

    // a word is taken whenever the queue has room for its job
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // front: frame tracking, checksum and reply selection
    cfr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .opcode       (opcode),
        .rx_byte      (rx_byte),
        .busy_req     (busy_req),
        .clear_buffer (clear_buffer),
        .clear_stop   (clear_stop),
        .job          (front_job)
    );

    // jobs waiting for the output side
    cfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_job (front_job),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back: serializes each job into one or five output words
    cfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tx_valid  (tx_valid),
        .tx_byte   (tx_byte),
        .last      (last),
        .status    (status)
    );

    assign frame_ready  = status.frame_ready;
    assign command_code = status.command_code;
    assign argument     = status.argument;
    assign stop_request = status.stop_request;
    assign auto_active  = status.auto_active;

endmodule

// ===== tb/sv/cfr_reply_checker.sv =====
module cfr_reply_checker
    import cfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    input  logic        busy_req,
    input  logic        clear_buffer,
    input  logic        clear_stop,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        tx_valid,
    input  logic [7:0]  tx_byte,
    input  logic        last,
    input  logic        frame_ready,
    input  logic [7:0]  command_code,
    input  logic [7:0]  argument,
    input  logic        stop_request,
    input  logic        auto_active,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        last;
        cfr_status_t status;
    } reply_word_t;

    // mirrored frame state
    logic [7:0]       frame_mem [FRAME_LEN];
    logic [IDX_W-1:0] wr_pos;
    logic             rx_active;
    logic             frame_held;
    logic             auto_on;
    logic             stop_on;

    reply_word_t expected_replies [$];

    task automatic predict_reply(input logic op, input logic [7:0] rx, input logic busy,
                                 input logic cb, input logic cs);
        logic [7:0]  reply [FRAME_LEN];
        logic [7:0]  sum;
        logic        replying;
        reply_word_t w;
        replying = 1'b0;
        if (op == OP_CONSUME) begin
            frame_held = 1'b0;
            rx_active  = 1'b0;
            auto_on    = 1'b0;
            if (cb)
                foreach (frame_mem[i]) frame_mem[i] = 8'h00;
            if (cs)
                stop_on = 1'b0;
        end else if (rx == START_BYTE && (!frame_held || busy)) begin
            rx_active    = 1'b1;
            frame_mem[0] = rx;
            wr_pos       = IDX_W'(1);
        end else if (rx_active) begin
            if (wr_pos < FRAME_LEN) begin
                frame_mem[wr_pos] = rx;
                if (rx == END_BYTE) begin
                    sum      = frame_mem[1] + frame_mem[2];
                    replying = 1'b1;
                    if (sum == frame_mem[3]) begin
                        for (int k = 0; k < FRAME_LEN; k++)
                            reply[k] = (!busy || frame_mem[2] == STOP_ARG)
                                       ? frame_mem[k] : BUSY_BYTE;
                        frame_held = 1'b1;
                        auto_on    = 1'b1;
                    end else begin
                        for (int k = 0; k < FRAME_LEN; k++)
                            reply[k] = NAK_BYTE;
                        frame_held = 1'b0;
                    end
                    wr_pos = '0;
                    if (frame_mem[2] == STOP_ARG && auto_on)
                        stop_on = 1'b1;
                end
            end else begin
                rx_active = 1'b0;
            end
            wr_pos = wr_pos + 1'b1;
        end

        w.status.frame_ready  = frame_held;
        w.status.command_code = frame_mem[1];
        w.status.argument     = frame_mem[2];
        w.status.stop_request = stop_on;
        w.status.auto_active  = auto_on;
        if (!replying) begin
            w.tx_valid = 1'b0;
            w.tx_byte  = 8'h00;
            w.last     = 1'b1;
            expected_replies.push_back(w);
        end else begin
            for (int k = 0; k < FRAME_LEN; k++) begin
                w.tx_valid = 1'b1;
                w.tx_byte  = reply[k];
                w.last     = (k == FRAME_LEN - 1);
                expected_replies.push_back(w);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        reply_word_t w;
        if (!rst_n) begin
            foreach (frame_mem[i]) frame_mem[i] = 8'h00;
            wr_pos     = '0;
            rx_active  = 1'b0;
            frame_held = 1'b0;
            auto_on    = 1'b0;
            stop_on    = 1'b0;
            errors     = 0;
            expected_replies.delete();
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_replies.size() == 0) begin
                    $error("unexpected output word: tx_byte %0h", tx_byte);
                    errors++;
                end else begin
                    w = expected_replies.pop_front();
                    check_field("tx_valid", w.tx_valid, tx_valid);
                    check_field("tx_byte", w.tx_byte, tx_byte);
                    check_field("last", w.last, last);
                    check_field("frame_ready", w.status.frame_ready, frame_ready);
                    check_field("command_code", w.status.command_code, command_code);
                    check_field("argument", w.status.argument, argument);
                    check_field("stop_request", w.status.stop_request, stop_request);
                    check_field("auto_active", w.status.auto_active, auto_active);
                end
            end
            if (in_valid && !in_stall)
                predict_reply(opcode, rx_byte, busy_req, clear_buffer, clear_stop);
        end
        pending <= expected_replies.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import cfr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no word moving on either side before the run is called hung
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_WORDS = 204;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = OP_RX_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic        busy_req = 1'b0;
    logic        clear_buffer = 1'b0;
    logic        clear_stop = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic        frame_ready;
    logic [7:0]  command_code;
    logic [7:0]  argument;
    logic        stop_request;
    logic        auto_active;

    int errors;
    int pending;
    int words_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    // when set, neither side inserts gaps: back-to-back stretches
    bit no_idle = 1'b0;

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    command_frame_receiver uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .rx_byte      (rx_byte),
        .busy_req     (busy_req),
        .clear_buffer (clear_buffer),
        .clear_stop   (clear_stop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tx_valid     (tx_valid),
        .tx_byte      (tx_byte),
        .last         (last),
        .frame_ready  (frame_ready),
        .command_code (command_code),
        .argument     (argument),
        .stop_request (stop_request),
        .auto_active  (auto_active)
    );

    // watches both channels, mirrors the framing logic, compares every output word
    cfr_reply_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .rx_byte      (rx_byte),
        .busy_req     (busy_req),
        .clear_buffer (clear_buffer),
        .clear_stop   (clear_stop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tx_valid     (tx_valid),
        .tx_byte      (tx_byte),
        .last         (last),
        .frame_ready  (frame_ready),
        .command_code (command_code),
        .argument     (argument),
        .stop_request (stop_request),
        .auto_active  (auto_active),
        .errors       (errors),
        .pending      (pending)
    );

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output side back-pressure: one free cycle, then a random-length stall
    always @(posedge clk) begin
        if (rst_n) begin
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end else begin
                stall_left <= pick_gap();
                out_stall  <= 1'b0;
            end
        end
    end

    // hang detector: any accepted word on either side resets the count
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL command_frame_receiver");
                $finish;
            end
        end
    end

    // present one word, optionally after a gap, and hold it until accepted
    task automatic send_word(input logic op, input logic [7:0] b, input logic busy,
                             input logic cb, input logic cs);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode       <= op;
        rx_byte      <= b;
        busy_req     <= busy;
        clear_buffer <= cb;
        clear_stop   <= cs;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    // received serial byte; the consume-only fields carry noise
    task automatic send_rx(input logic [7:0] b, input logic busy);
        send_word(OP_RX_BYTE, b, busy, 1'($urandom), 1'($urandom));
    endtask

    // handler consumed the frame; byte and busy carry noise
    task automatic send_consume(input logic cb, input logic cs);
        send_word(OP_CONSUME, 8'($urandom), 1'($urandom), cb, cs);
    endtask

    initial begin
        logic [7:0] cmd;
        logic [7:0] arg;
        logic [7:0] chk;
        logic       busy;
        int         kind;
        int         extra;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        // end byte with no frame open is ignored
        send_rx(END_BYTE, 1'b0);
        // clean frame, not busy: echoed, frame pending and auto mode rise
        send_rx(START_BYTE, 1'b0);
        send_rx(8'h01, 1'b0);
        send_rx(8'h02, 1'b0);
        send_rx(8'h03, 1'b0);
        send_rx(END_BYTE, 1'b0);
        // start byte while pending and idle dispenser is plain data at byte 1,
        // then the end byte lands at byte 2 and the stale checksum fails: NAK
        send_rx(START_BYTE, 1'b0);
        send_rx(END_BYTE, 1'b0);
        // consume clearing everything
        send_consume(1'b1, 1'b1);
        // stop argument while busy: echoed anyway, stop request rises
        send_rx(START_BYTE, 1'b1);
        send_rx(8'h10, 1'b1);
        send_rx(STOP_ARG, 1'b1);
        send_rx(8'h05, 1'b1);
        send_rx(END_BYTE, 1'b1);
        // busy dispenser reopens a frame while one is pending: busy reply
        send_rx(START_BYTE, 1'b1);
        send_rx(8'h20, 1'b1);
        send_rx(8'h30, 1'b1);
        send_rx(8'h50, 1'b1);
        send_rx(END_BYTE, 1'b1);
        // consume that keeps buffer and stop flag
        send_consume(1'b0, 1'b0);
        // overlong frame: byte past the last slot drops receiving
        send_rx(START_BYTE, 1'b0);
        send_rx(8'hFF, 1'b0);
        send_rx(8'hFF, 1'b0);
        send_rx(8'hFE, 1'b0);
        send_rx(8'h11, 1'b0);
        send_rx(8'h22, 1'b0);

        // ---------------- random part ----------------
        // mostly well-formed frames with random content, some consumes,
        // stray bytes, short and overlong frames and bad checksums
        while (words_sent < RANDOM_WORDS + 26) begin
            if ($urandom_range(0, 5) == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
                send_consume(($urandom_range(0, 3) == 0), 1'($urandom));
            end else if (kind < 20) begin
                send_rx(8'($urandom), 1'($urandom));
            end else begin
                busy = 1'($urandom);
                cmd  = 8'($urandom);
                arg  = ($urandom_range(0, 5) == 0) ? STOP_ARG : 8'($urandom);
                chk  = ($urandom_range(0, 3) != 0) ? 8'(cmd + arg) : 8'($urandom);
                send_rx(START_BYTE, busy);
                kind = $urandom_range(0, 7);
                if (kind == 0) begin
                    // short frame: end byte early, stale slots take part
                    extra = $urandom_range(0, 2);
                    if (extra > 0) send_rx(cmd, busy);
                    if (extra > 1) send_rx(arg, busy);
                end else begin
                    send_rx(cmd, busy);
                    send_rx(arg, busy);
                    send_rx(chk, busy);
                    // overlong frame pushes the end byte past the last slot
                    if (kind == 1) begin
                        extra = $urandom_range(1, 2);
                        repeat (extra) send_rx(8'($urandom), busy);
                    end
                end
                send_rx(END_BYTE, ($urandom_range(0, 3) == 0) ? !busy : busy);
            end
        end

        // drain: let the checker see the last push, then wait it empty
        in_valid <= 1'b0;
        no_idle = 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("PASS command_frame_receiver");
        else
            $display("FAIL command_frame_receiver");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cfr_pkg.sv
rtl/cfr_front.sv
rtl/cfr_queue.sv
rtl/cfr_back.sv
rtl/command_frame_receiver.sv
tb/sv/cfr_reply_checker.sv
tb/sv/tb.sv
